// ===== sv/qri_pkg.sv =====
// shared types and constants for the quaternion rate integrator
// no dependencies
package qri_pkg;

  localparam logic [15:0] STEP_TIME_RESET = 16'd655;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 15;
  localparam int LATENCY = 55;

  typedef logic [3:0][31:0] pvec_t;

  typedef struct packed {
    logic vld;
    logic [31:0] len;
  } root_t;

endpackage

// ===== sv/qri_front.sv =====
// front end: hamilton product, step scaling, rounding and sum of squares
// depends on qri_pkg
module qri_front (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_in,
  input  logic signed [15:0] qw,
  input  logic signed [15:0] qx,
  input  logic signed [15:0] qy,
  input  logic signed [15:0] qz,
  input  logic signed [15:0] wx,
  input  logic signed [15:0] wy,
  input  logic signed [15:0] wz,
  input  logic [15:0] dt,
  output logic vld_out,
  output logic [63:0] sum_sq,
  output qri_pkg::pvec_t pvec
);

  logic [5:0] vld_r, vld_nxt;
  logic signed [31:0] prod_r [12];
  logic signed [15:0] q1_r [4];
  logic signed [15:0] q2_r [4];
  logic signed [15:0] q3_r [4];
  logic signed [33:0] d_r [4];
  logic signed [33:0] d_nxt [4];
  logic signed [50:0] dd_r [4];
  logic [31:0] p4_r [4];
  logic [31:0] p5_r [4];
  logic [63:0] sq_r [4];
  logic [31:0] p6_r [4];
  logic [63:0] sum_r;

  assign vld_nxt = {vld_r[4:0], vld_in};

  always_comb begin
    d_nxt[0] = -34'(prod_r[0]) - 34'(prod_r[1]) - 34'(prod_r[2]);
    d_nxt[1] =  34'(prod_r[3]) + 34'(prod_r[4]) - 34'(prod_r[5]);
    d_nxt[2] = -34'(prod_r[6]) + 34'(prod_r[7]) + 34'(prod_r[8]);
    d_nxt[3] =  34'(prod_r[9]) - 34'(prod_r[10]) + 34'(prod_r[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [51:0] v;
    prod_r[0]  <= wx * qx;
    prod_r[1]  <= wy * qy;
    prod_r[2]  <= wz * qz;
    prod_r[3]  <= wx * qw;
    prod_r[4]  <= wy * qz;
    prod_r[5]  <= wz * qy;
    prod_r[6]  <= wx * qz;
    prod_r[7]  <= wy * qw;
    prod_r[8]  <= wz * qx;
    prod_r[9]  <= wx * qy;
    prod_r[10] <= wy * qx;
    prod_r[11] <= wz * qw;
    q1_r[0] <= qw;
    q1_r[1] <= qx;
    q1_r[2] <= qy;
    q1_r[3] <= qz;
    for (int i = 0; i < 4; i++) begin
      q2_r[i] <= q1_r[i];
      d_r[i] <= d_nxt[i];
      q3_r[i] <= q2_r[i];
      dd_r[i] <= d_r[i] * $signed({1'b0, dt});
      // round half up to units of 2^-24
      v = (52'(q3_r[i]) <<< 27) + 52'(dd_r[i]) + 52'sd65536;
      p4_r[i] <= v[48:17];
      sq_r[i] <= 64'($signed(p4_r[i]) * $signed(p4_r[i]));
      p5_r[i] <= p4_r[i];
      p6_r[i] <= p5_r[i];
    end
    sum_r <= sq_r[0] + sq_r[1] + sq_r[2] + sq_r[3];
  end

  assign vld_out = vld_r[5];
  assign sum_sq = sum_r;
  assign pvec = {p6_r[3], p6_r[2], p6_r[1], p6_r[0]};

endmodule

// ===== sv/qri_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on qri_pkg
module qri_sqrt (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_in,
  input  logic [63:0] sum_sq,
  input  qri_pkg::pvec_t pvec_in,
  output qri_pkg::root_t root,
  output qri_pkg::pvec_t pvec_out
);

  logic [34:0] rem_s [0:qri_pkg::SQRT_STEPS];
  logic [31:0] root_s [0:qri_pkg::SQRT_STEPS];
  logic [63:0] s_s [0:qri_pkg::SQRT_STEPS];
  qri_pkg::pvec_t p_s [0:qri_pkg::SQRT_STEPS];
  logic vld_s [0:qri_pkg::SQRT_STEPS];

  assign rem_s[0] = '0;
  assign root_s[0] = '0;
  assign s_s[0] = sum_sq;
  assign p_s[0] = pvec_in;
  assign vld_s[0] = vld_in;

  for (genvar g = 0; g < qri_pkg::SQRT_STEPS; g++) begin : g_stage
    logic [34:0] rem_r, rem_nxt, trial;
    logic [31:0] root_r, root_nxt;
    logic [63:0] s_r;
    qri_pkg::pvec_t p_r;
    logic vld_r;

    always_comb begin
      rem_nxt = {rem_s[g][32:0], s_s[g][63-2*g -: 2]};
      trial = {1'b0, root_s[g], 2'b01};
      if (rem_nxt >= trial) begin
        rem_nxt = rem_nxt - trial;
        root_nxt = {root_s[g][30:0], 1'b1};
      end else begin
        root_nxt = {root_s[g][30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_s[g];
      end
    end

    always_ff @(posedge clk) begin
      rem_r <= rem_nxt;
      root_r <= root_nxt;
      s_r <= s_s[g];
      p_r <= p_s[g];
    end

    assign rem_s[g+1] = rem_r;
    assign root_s[g+1] = root_r;
    assign s_s[g+1] = s_r;
    assign p_s[g+1] = p_r;
    assign vld_s[g+1] = vld_r;
  end

  assign root.vld = vld_s[qri_pkg::SQRT_STEPS];
  assign root.len = root_s[qri_pkg::SQRT_STEPS];
  assign pvec_out = p_s[qri_pkg::SQRT_STEPS];

endmodule

// ===== sv/qri_div.sv =====
// pipelined rounded division of the four components by the length
// depends on qri_pkg
module qri_div (
  input  logic clk,
  input  logic rst_n,
  input  qri_pkg::root_t root,
  input  qri_pkg::pvec_t pvec,
  output logic vld_out,
  output logic zero_out,
  output logic [3:0][15:0] quat_out
);

  localparam int N = qri_pkg::DIV_STEPS;

  logic vld_s [0:N];
  logic [31:0] len_s [0:N];
  logic [3:0] neg_s [0:N];
  logic [3:0][32:0] rem_s [0:N];
  logic [3:0][14:0] nlo_s [0:N];
  logic [3:0][14:0] quo_s [0:N];

  // prep stage: magnitude, scale by 2^14 and add half the divisor
  logic vld0_r;
  logic [31:0] len0_r;
  logic [3:0] neg0_r;
  logic [3:0][32:0] rem0_r;
  logic [3:0][14:0] nlo0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= root.vld;
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] mag;
    logic [45:0] num;
    len0_r <= root.len;
    for (int i = 0; i < 4; i++) begin
      neg0_r[i] <= pvec[i][31];
      mag = pvec[i][31] ? 32'(-pvec[i]) : pvec[i];
      num = {mag, 14'b0} + 46'(root.len >> 1);
      rem0_r[i] <= 33'(num[45:15]);
      nlo0_r[i] <= num[14:0];
    end
  end

  assign vld_s[0] = vld0_r;
  assign len_s[0] = len0_r;
  assign neg_s[0] = neg0_r;
  assign rem_s[0] = rem0_r;
  assign nlo_s[0] = nlo0_r;
  assign quo_s[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic vld_r;
    logic [31:0] len_r;
    logic [3:0] neg_r;
    logic [3:0][32:0] rem_r, rem_nxt;
    logic [3:0][14:0] nlo_r, quo_r, quo_nxt;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        rem_nxt[i] = {rem_s[g][i][31:0], nlo_s[g][i][14]};
        if (rem_nxt[i] >= 33'(len_s[g])) begin
          rem_nxt[i] = rem_nxt[i] - 33'(len_s[g]);
          quo_nxt[i] = {quo_s[g][i][13:0], 1'b1};
        end else begin
          quo_nxt[i] = {quo_s[g][i][13:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_s[g];
      end
    end

    always_ff @(posedge clk) begin
      len_r <= len_s[g];
      neg_r <= neg_s[g];
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      for (int i = 0; i < 4; i++) begin
        nlo_r[i] <= {nlo_s[g][i][13:0], 1'b0};
      end
    end

    assign vld_s[g+1] = vld_r;
    assign len_s[g+1] = len_r;
    assign neg_s[g+1] = neg_r;
    assign rem_s[g+1] = rem_r;
    assign nlo_s[g+1] = nlo_r;
    assign quo_s[g+1] = quo_r;
  end

  // quotient is at most 2^14, so no saturation is reached
  always_comb begin
    zero_out = (len_s[N] == '0);
    for (int i = 0; i < 4; i++) begin
      if (zero_out) begin
        quat_out[i] = '0;
      end else if (neg_s[N][i]) begin
        quat_out[i] = -{1'b0, quo_s[N][i]};
      end else begin
        quat_out[i] = {1'b0, quo_s[N][i]};
      end
    end
  end

  assign vld_out = vld_s[N];

endmodule

// ===== sv/quaternion_rate_integrator.sv =====
// top level of the quaternion rate integrator
// depends on qri_pkg, qri_front, qri_sqrt, qri_div
//
// takes an orientation quaternion (Q2.14) and a body rate (Q5.10 rad/s),
// integrates one step of dt = step_time * 2^-16 s and renormalizes.
// request channel: in_* fields are taken at a clock edge with start high
// and busy low; busy is always low, so a new request may enter every cycle.
// result channel: out_valid is high for one cycle with out_w/x/y/z and
// out_zero_length; there is no back pressure, results cannot be held off.
// from accept to out_valid a request passes 6 front stages (products,
// sums, step scaling, rounding, squares, sum), 32 square root stages (one
// root bit each), one divider prep stage, 15 divider stages (one quotient
// bit each) and the output register. throughput is one request per cycle.
// cfg port: cfg_data is written to step_time when cfg_valid is high;
// cfg_ready is always high. write it only while no request is in flight.
// synchronous active-low reset clears the valid pipeline and sets
// step_time to 655.
module quaternion_rate_integrator (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic signed [15:0] in_rate_z,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [15:0] cfg_data,
  output logic out_valid,
  output logic signed [15:0] out_w,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic out_zero_length
);

  logic [15:0] step_time_r;
  logic fr_vld;
  logic [63:0] fr_sum;
  qri_pkg::pvec_t fr_p, sq_p;
  qri_pkg::root_t sq_root;
  logic dv_vld, dv_zero;
  logic [3:0][15:0] dv_quat;
  logic out_valid_r;
  logic [3:0][15:0] quat_r;
  logic zero_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= qri_pkg::STEP_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_time_r <= cfg_data;
    end
  end

  qri_front u_front (
    .clk(clk), .rst_n(rst_n), .vld_in(start && !busy),
    .qw(in_quat_w), .qx(in_quat_x), .qy(in_quat_y), .qz(in_quat_z),
    .wx(in_rate_x), .wy(in_rate_y), .wz(in_rate_z), .dt(step_time_r),
    .vld_out(fr_vld), .sum_sq(fr_sum), .pvec(fr_p)
  );

  qri_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .vld_in(fr_vld), .sum_sq(fr_sum),
    .pvec_in(fr_p), .root(sq_root), .pvec_out(sq_p)
  );

  qri_div u_div (
    .clk(clk), .rst_n(rst_n), .root(sq_root), .pvec(sq_p),
    .vld_out(dv_vld), .zero_out(dv_zero), .quat_out(dv_quat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    quat_r <= dv_quat;
    zero_r <= dv_zero;
  end

  assign out_valid = out_valid_r;
  assign out_w = quat_r[0];
  assign out_x = quat_r[1];
  assign out_y = quat_r[2];
  assign out_z = quat_r[3];
  assign out_zero_length = zero_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, qri_pkg::LATENCY))
    else $error("result without matching request");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_w <= 16'sd16384 && out_w >= -16'sd16384 &&
                   out_x <= 16'sd16384 && out_x >= -16'sd16384 &&
                   out_y <= 16'sd16384 && out_y >= -16'sd16384 &&
                   out_z <= 16'sd16384 && out_z >= -16'sd16384))
    else $error("normalized component out of range");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_length) |->
      (out_w == '0 && out_x == '0 && out_y == '0 && out_z == '0))
    else $error("zero length with nonzero components");

endmodule
